FILE: rtl/link_frame_deframer_unit_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef LINK_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define LINK_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LFD_ASSERT_ALWAYS(name, clk_s, rst_s, cond) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("lfd assertion failed");

// Check that a consequent holds in the cycle after an antecedent.
`define LFD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lfd assertion failed");

`endif

FILE: rtl/lfd_pkg.sv
// Types and constants of the link frame deframer.
`default_nettype none

package lfd_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned FILL_W    = $clog2(HDR_BYTES + 1);

  localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] HDR_LEN     = 16'(HDR_BYTES);

  typedef struct packed {
    logic        is_payload;
    logic [15:0] packet_length;
    logic [7:0]  control_bits;
    logic [7:0]  sequence_number;
    logic [7:0]  session_id;
    logic [7:0]  payload_byte;
    logic        last_of_packet;
    logic        packet_good;
  } lfd_result_t;

endpackage

`default_nettype wire

FILE: rtl/link_frame_deframer_unit.sv
// Top level of the link frame deframer.
// A byte that causes a result has it registered in the result queue; the result ports show the oldest queued beat.
// Throughput: one byte per cycle while full is low; full rises only when all QUEUE_DEPTH result slots hold beats.
// The header check (nine-byte sum, sync and length compare) is done in the accepting cycle.
// Reset (rst, synchronous): empties the result queue, clears the window fill, returns to hunting.
`default_nettype none

module link_frame_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte,
  output      logic        empty,
  input  wire logic        pop,
  output      logic        is_payload,
  output      logic [15:0] packet_length,
  output      logic [7:0]  control_bits,
  output      logic [7:0]  sequence_number,
  output      logic [7:0]  session_id,
  output      logic [7:0]  payload_byte,
  output      logic        last_of_packet,
  output      logic        packet_good
);
  import lfd_pkg::*;

  logic        in_beat, out_beat, res_valid;
  lfd_result_t res, head;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  lfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .beat      (in_beat),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (out_beat),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign is_payload      = head.is_payload;
  assign packet_length   = head.packet_length;
  assign control_bits    = head.control_bits;
  assign sequence_number = head.sequence_number;
  assign session_id      = head.session_id;
  assign payload_byte    = head.payload_byte;
  assign last_of_packet  = head.last_of_packet;
  assign packet_good     = head.packet_good;

endmodule

`default_nettype wire

FILE: rtl/lfd_front.sv
// Front part: header hunt over a sliding window and payload tracking.
`default_nettype none
`include "link_frame_deframer_unit_macros.svh"

module lfd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 beat,
  input  wire logic [7:0]           data_byte,
  output      logic                 res_valid,
  output      lfd_pkg::lfd_result_t res
);
  import lfd_pkg::*;

  logic [7:0]        win [HDR_BYTES];
  logic [7:0]        cand [HDR_BYTES];
  logic [FILL_W-1:0] fill, fill_next;
  logic              in_payload, in_payload_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [7:0]        payload_sum, payload_sum_next;
  logic [7:0]        hdr_sum;
  logic [15:0]       cand_len;
  logic [7:0]        pay_sum_new;
  logic              hit;

  // Window as it stands after the incoming byte is shifted in.
  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) begin
      cand[i] = win[i+1];
    end
    cand[HDR_BYTES-1] = data_byte;
  end

  always_comb begin
    hdr_sum = 8'd0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_sum = hdr_sum + cand[i];
    end
  end

  assign cand_len    = {cand[2], cand[3]};
  assign pay_sum_new = payload_sum + data_byte;
  assign hit = (fill >= FILL_W'(HDR_BYTES - 1)) && (cand[0] == SYNC_FIRST) &&
               (cand[1] == SYNC_SECOND) && (hdr_sum == 8'd0) &&
               (cand_len >= HDR_LEN);

  always_comb begin
    fill_next        = fill;
    in_payload_next  = in_payload;
    bytes_left_next  = bytes_left;
    payload_sum_next = payload_sum;
    res_valid        = 1'b0;
    res              = '0;
    if (beat) begin
      if (in_payload) begin
        payload_sum_next   = pay_sum_new;
        bytes_left_next    = bytes_left - 16'd1;
        res_valid          = 1'b1;
        res.is_payload     = 1'b1;
        res.payload_byte   = data_byte;
        if (bytes_left == 16'd1) begin
          in_payload_next    = 1'b0;
          res.last_of_packet = 1'b1;
          res.packet_good    = (pay_sum_new == 8'd0);
        end
      end else begin
        fill_next = (fill == FILL_W'(HDR_BYTES)) ? fill : fill + FILL_W'(1);
        if (hit) begin
          fill_next           = '0;
          payload_sum_next    = 8'd0;
          res_valid           = 1'b1;
          res.packet_length   = cand_len;
          res.control_bits    = cand[4];
          res.sequence_number = cand[5];
          res.session_id      = cand[7];
          if (cand_len == HDR_LEN) begin
            bytes_left_next    = 16'd0;
            res.last_of_packet = 1'b1;
            res.packet_good    = 1'b1;
          end else begin
            bytes_left_next = cand_len - HDR_LEN;
            in_payload_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      in_payload  <= 1'b0;
      bytes_left  <= 16'd0;
      payload_sum <= 8'd0;
    end else begin
      fill        <= fill_next;
      in_payload  <= in_payload_next;
      bytes_left  <= bytes_left_next;
      payload_sum <= payload_sum_next;
    end
  end

  // Shift line; only advance while hunting.
  always_ff @(posedge clk) begin
    if (beat && !in_payload) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        win[i] <= cand[i];
      end
    end
  end

  `LFD_ASSERT_ALWAYS(a_fill_range, clk, rst, fill <= FILL_W'(HDR_BYTES))
  `LFD_ASSERT_ALWAYS(a_payload_left, clk, rst, !in_payload || (bytes_left != 16'd0))
  `LFD_ASSERT_NEXT(a_last_ends, clk, rst, res_valid && res.last_of_packet, !in_payload)

endmodule

`default_nettype wire

FILE: rtl/lfd_queue.sv
// Result queue between the front part and the output ports.
`default_nettype none
`include "link_frame_deframer_unit_macros.svh"

module lfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire lfd_pkg::lfd_result_t wr_data,
  input  wire logic                 rd_en,
  output      lfd_pkg::lfd_result_t rd_data,
  output      logic                 full,
  output      logic                 empty
);
  import lfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lfd_result_t       mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `LFD_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(DEPTH))
  `LFD_ASSERT_ALWAYS(a_no_overflow, clk, rst, !(wr_en && full))
  `LFD_ASSERT_ALWAYS(a_no_underflow, clk, rst, !(rd_en && empty))

endmodule

`default_nettype wire

FILE: bench/link_frame_deframer_unit_test.sv
// Self-checking bench for the link frame deframer: directed byte table, then random link traffic.
module link_frame_deframer_unit_test;
  import lfd_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned RANDOM_BYTES  = 1950;

  // How a table row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_BEAT,
    ROW_TYPED
  } row_mode_t;

  typedef struct packed {
    logic [7:0]  data;
    row_mode_t   mode;
    lfd_result_t beat;
  } link_row_t;

  localparam lfd_result_t NO_BEAT = '0;
  localparam lfd_result_t HDR_ONLY_MAX_BEAT =
    {1'b0, 16'd9, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1};
  localparam lfd_result_t BAD_TAIL_BEAT =
    {1'b1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b1, 1'b0};

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        is_payload;
  logic [15:0] packet_length;
  logic [7:0]  control_bits;
  logic [7:0]  sequence_number;
  logic [7:0]  session_id;
  logic [7:0]  payload_byte;
  logic        last_of_packet;
  logic        packet_good;

  link_frame_deframer_unit uut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .empty           (empty),
    .pop             (pop),
    .is_payload      (is_payload),
    .packet_length   (packet_length),
    .control_bits    (control_bits),
    .sequence_number (sequence_number),
    .session_id      (session_id),
    .payload_byte    (payload_byte),
    .last_of_packet  (last_of_packet),
    .packet_good     (packet_good)
  );

  // Deframer state as seen by the predictor.
  logic [7:0]  hunt_window [HDR_BYTES];
  int unsigned hunt_fill;
  bit          in_body;
  logic [15:0] body_left;
  logic [7:0]  body_sum;

  lfd_result_t expected_beats [$];
  link_row_t   plan [DIRECTED_ROWS];

  int error_count   = 0;
  int bytes_sent    = 0;
  int header_beats  = 0;
  int payload_beats = 0;
  int good_packets  = 0;
  int bad_packets   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout: result stream did not drain");
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, a few long ones, and calm stretches with none.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the deframer by one link byte; returns 1 when a result beat is due.
  function automatic bit deframe_step(input logic [7:0] b, output lfd_result_t res);
    logic [7:0]  hsum;
    logic [15:0] len;
    int          i;
    res = '0;
    if (in_body && body_left != 0) begin
      body_sum  = body_sum + b;
      body_left = body_left - 16'd1;
      res.is_payload   = 1'b1;
      res.payload_byte = b;
      if (body_left == 0) begin
        in_body = 1'b0;
        res.last_of_packet = 1'b1;
        res.packet_good    = (body_sum == 8'h00);
      end
      return 1'b1;
    end
    in_body = 1'b0;
    if (hunt_fill < HDR_BYTES) begin
      hunt_window[hunt_fill] = b;
      hunt_fill++;
    end else begin
      for (i = 0; i < HDR_BYTES - 1; i++) hunt_window[i] = hunt_window[i + 1];
      hunt_window[HDR_BYTES - 1] = b;
    end
    if (hunt_fill < HDR_BYTES) return 1'b0;
    if (hunt_window[0] != SYNC_FIRST || hunt_window[1] != SYNC_SECOND) return 1'b0;
    hsum = 8'h00;
    for (i = 0; i < HDR_BYTES; i++) hsum = hsum + hunt_window[i];
    if (hsum != 8'h00) return 1'b0;
    len = {hunt_window[2], hunt_window[3]};
    if (len < HDR_LEN) return 1'b0;
    hunt_fill = 0;
    body_sum  = 8'h00;
    res.packet_length   = len;
    res.control_bits    = hunt_window[4];
    res.sequence_number = hunt_window[5];
    res.session_id      = hunt_window[7];
    if (len == HDR_LEN) begin
      body_left = 16'd0;
      res.last_of_packet = 1'b1;
      res.packet_good    = 1'b1;
    end else begin
      body_left = len - HDR_LEN;
      in_body   = 1'b1;
    end
    return 1'b1;
  endfunction

  // Offer one byte after a random gap; hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input row_mode_t mode,
                           input lfd_result_t typed_beat);
    int          gap;
    bit          produced;
    lfd_result_t predicted;
    gap = pick_gap((bytes_sent / 200) % 5 == 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    produced = deframe_step(b, predicted);
    case (mode)
      ROW_PREDICT: if (produced) expected_beats.push_back(predicted);
      ROW_TYPED:   expected_beats.push_back(typed_beat);
      default:     ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result side: check each popped beat against the oldest expectation.
  initial begin : drain
    int          hold;
    lfd_result_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat: is_payload %b payload_byte %h last %b",
                   $time, is_payload, payload_byte, last_of_packet);
          error_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("is_payload", 16'(want.is_payload), 16'(is_payload));
          check_field("packet_length", want.packet_length, packet_length);
          check_field("control_bits", 16'(want.control_bits), 16'(control_bits));
          check_field("sequence_number", 16'(want.sequence_number), 16'(sequence_number));
          check_field("session_id", 16'(want.session_id), 16'(session_id));
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
          check_field("last_of_packet", 16'(want.last_of_packet), 16'(last_of_packet));
          check_field("packet_good", 16'(want.packet_good), 16'(packet_good));
          if (want.is_payload) payload_beats++;
          else header_beats++;
          if (want.last_of_packet) begin
            if (want.packet_good) good_packets++;
            else bad_packets++;
          end
        end
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = pick_gap(((header_beats + payload_beats) / 150) % 5 == 4);
      end
    end
  end

  initial begin
    int          i;
    int          kind;
    int          sel;
    int          body;
    int          n;
    int          idx;
    logic [7:0]  hdr [HDR_BYTES];
    logic [7:0]  csum;
    logic [7:0]  b;
    logic [15:0] len;

    for (i = 0; i < HDR_BYTES; i++) hunt_window[i] = 8'h00;
    hunt_fill = 0;
    in_body   = 1'b0;
    body_left = 16'd0;
    body_sum  = 8'h00;

    // Stray 0xFF, then a header-only packet with all-ones fields; the first full
    // window fails on sync and the slide by one byte finds the header.
    plan[0]  = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[1]  = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[2]  = '{8'h5A, ROW_NO_BEAT, NO_BEAT};
    plan[3]  = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[4]  = '{8'h09, ROW_NO_BEAT, NO_BEAT};
    plan[5]  = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[6]  = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[7]  = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[8]  = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[9]  = '{8'hA1, ROW_TYPED, HDR_ONLY_MAX_BEAT};
    // Ten-byte packet whose single payload byte breaks the checksum.
    plan[10] = '{8'hFF, ROW_NO_BEAT, NO_BEAT};
    plan[11] = '{8'h5A, ROW_NO_BEAT, NO_BEAT};
    plan[12] = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[13] = '{8'h0A, ROW_NO_BEAT, NO_BEAT};
    plan[14] = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[15] = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[16] = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[17] = '{8'h00, ROW_NO_BEAT, NO_BEAT};
    plan[18] = '{8'h9D, ROW_PREDICT, NO_BEAT};
    plan[19] = '{8'h5A, ROW_TYPED, BAD_TAIL_BEAT};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) send_byte(plan[i].data, plan[i].mode, plan[i].beat);

    // Random traffic: mostly well-formed packets, some broken headers, some noise.
    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      sel  = 0;
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      len  = 16'(HDR_BYTES + body);
      if (kind >= 65 && kind < 80) begin
        sel = $urandom_range(0, 2);
        if (sel == 1) len = 16'($urandom_range(0, HDR_BYTES - 1));
        else len = 16'($urandom_range(0, 65535));
      end
      hdr[0] = SYNC_FIRST;
      hdr[1] = SYNC_SECOND;
      hdr[2] = len[15:8];
      hdr[3] = len[7:0];
      for (i = 4; i < HDR_BYTES - 1; i++) hdr[i] = 8'($urandom_range(0, 255));
      csum = 8'h00;
      for (i = 0; i < HDR_BYTES - 1; i++) csum = csum + hdr[i];
      hdr[HDR_BYTES - 1] = 8'h00 - csum;
      if (kind >= 65 && kind < 80) begin
        // Break sync or the header checksum; a short length is already broken.
        idx = $urandom_range(0, 1);
        if (sel == 0) hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
        else if (sel == 2) hdr[HDR_BYTES - 1] = hdr[HDR_BYTES - 1] ^ 8'($urandom_range(1, 255));
        body = $urandom_range(0, 10);
      end
      if (kind < 80) begin
        for (i = 0; i < HDR_BYTES; i++) send_byte(hdr[i], ROW_PREDICT, NO_BEAT);
        csum = 8'h00;
        for (i = 0; i < body; i++) begin
          b = 8'($urandom_range(0, 255));
          // Close most good packets with a matching checksum byte.
          if (kind < 65 && i == body - 1 && $urandom_range(0, 3) != 0) b = 8'h00 - csum;
          csum = csum + b;
          send_byte(b, ROW_PREDICT, NO_BEAT);
        end
      end else begin
        n = $urandom_range(1, 16);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       b = SYNC_FIRST;
            1:       b = SYNC_SECOND;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b, ROW_PREDICT, NO_BEAT);
        end
      end
    end
    push <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Fed %0d link bytes (%0d from the directed table) with random gaps on both sides.",
             bytes_sent, DIRECTED_ROWS);
    $display("Checked %0d header beats and %0d payload beats; %0d packets good, %0d bad.",
             header_beats, payload_beats, good_packets, bad_packets);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
